// ===== rtl/lis_pkg.sv =====
// Package for the linear insertion sorter: sizes, state encoding and the
// command/status structs passed between controller and datapath.
// No dependencies.
`default_nettype none

package lis_pkg;

    // Number of cells in the sorted store.
    localparam int DEPTH  = 32;
    // Element width.
    localparam int DATA_W = 32;
    // Fill count must hold 0 to DEPTH inclusive.
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Controller states.
    typedef enum logic [0:0] {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;   // insert i_value into the cell row
        logic drain;    // shift the row down by one and emit cell 0
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_one; // exactly one element left in the store
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/lis_ctrl.sv =====
// Controller of the linear insertion sorter: loads elements until the last
// flag, then drains the sorted row. Depends on lis_pkg.
`default_nettype none

module lis_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_last,
    input  wire lis_pkg::t_stat i_stat,
    output lis_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    lis_pkg::t_state r_state;
    lis_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lis_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a transaction with the last flag starts the drain, which
    // ends after the final element leaves the store.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lis_pkg::ST_LOAD: begin
                if (i_start && i_last) begin
                    n_state = lis_pkg::ST_DRAIN;
                end
            end
            lis_pkg::ST_DRAIN: begin
                if (i_stat.last_one) begin
                    n_state = lis_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = lis_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs: commands to the datapath and the busy flag.
    always_comb begin
        o_cmd.insert = 1'b0;
        o_cmd.drain  = 1'b0;
        o_busy       = 1'b0;
        case (r_state)
            lis_pkg::ST_LOAD: begin
                o_cmd.insert = i_start;
            end
            lis_pkg::ST_DRAIN: begin
                o_cmd.drain = 1'b1;
                o_busy      = 1'b1;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lis_dp.sv =====
// Datapath of the linear insertion sorter: a row of compare-and-shift cells,
// the fill count and the overflow flag. Depends on lis_pkg.
`default_nettype none

module lis_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire lis_pkg::t_cmd               i_cmd,
    input  wire logic signed [lis_pkg::DATA_W-1:0] i_value,
    output lis_pkg::t_stat                   o_stat,
    output logic signed [lis_pkg::DATA_W-1:0] o_value_res,
    output logic                             o_last_res,
    output logic                             o_overflow
);

    logic signed [lis_pkg::DATA_W-1:0] r_cell [lis_pkg::DEPTH];
    logic signed [lis_pkg::DATA_W-1:0] n_cell [lis_pkg::DEPTH];
    logic [lis_pkg::CNT_W-1:0]         r_count;
    logic [lis_pkg::CNT_W-1:0]         n_count;
    logic                              r_ovf;
    logic                              n_ovf;
    logic [lis_pkg::DEPTH-1:0]         w_gt;
    logic                              w_full;

    assign w_full = (r_count == lis_pkg::CNT_W'(lis_pkg::DEPTH));

    // Each occupied cell compares its element with the new one. Equal values
    // do not move, so a new element lands after its equals.
    always_comb begin
        for (int i = 0; i < lis_pkg::DEPTH; i++) begin
            w_gt[i] = (lis_pkg::CNT_W'(i) < r_count) && (r_cell[i] > i_value);
        end
    end

    // Cell update: a cell holding a greater element, or the first empty
    // cell, takes its lower neighbor if that one moves up, else the new
    // element. During the drain every cell but the last takes its upper neighbor.
    always_comb begin
        for (int i = 0; i < lis_pkg::DEPTH; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.drain) begin
                if (i < lis_pkg::DEPTH - 1) begin
                    n_cell[i] = r_cell[(i + 1) % lis_pkg::DEPTH];
                end
            end else if (i_cmd.insert && !w_full &&
                         (w_gt[i] || (lis_pkg::CNT_W'(i) == r_count))) begin
                if ((i > 0) && w_gt[(i + lis_pkg::DEPTH - 1) % lis_pkg::DEPTH]) begin
                    n_cell[i] = r_cell[(i + lis_pkg::DEPTH - 1) % lis_pkg::DEPTH];
                end else begin
                    n_cell[i] = i_value;
                end
            end
        end
    end

    // Fill count and overflow flag.
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_cmd.drain) begin
            n_count = r_count - lis_pkg::CNT_W'(1);
            if (o_stat.last_one) begin
                n_ovf = 1'b0;
            end
        end else if (i_cmd.insert) begin
            if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + lis_pkg::CNT_W'(1);
            end
        end
    end

    // Cell row: payload, no reset.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < lis_pkg::DEPTH; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // Results come straight from cell 0 and the registered flags.
    assign o_stat.last_one = (r_count == lis_pkg::CNT_W'(1));
    assign o_value_res     = r_cell[0];
    assign o_last_res      = o_stat.last_one;
    assign o_overflow      = r_ovf;

endmodule

`default_nettype wire

// ===== rtl/linear_insertion_sorter.sv =====
// Top level of the linear insertion sorter: joins the controller and the
// cell-row datapath. Depends on lis_pkg, lis_ctrl and lis_dp.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  input    | start, busy        | i_value (signed 32), i_last
//  result   | o_valid (strobe)   | o_value_res (signed 32), o_last_res,
//           |                    | o_overflow
//
// An element is taken in every cycle with start high and busy low; the cell
// row compares and shifts combinationally, so loading runs at one element a
// cycle. After the element with the last flag, busy is high until every held
// element has left, and one result is strobed per cycle in ascending order.
// Reset empties the store and clears the overflow flag.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module linear_insertion_sorter (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [lis_pkg::DATA_W-1:0]  i_value,
    input  wire logic                               i_last,
    output logic                                    o_valid,
    output logic signed [lis_pkg::DATA_W-1:0]       o_value_res,
    output logic                                    o_last_res,
    output logic                                    o_overflow
);

    lis_pkg::t_cmd  w_cmd;
    lis_pkg::t_stat w_stat;

    // Sequencing of load and drain.
    lis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_last),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Sorted cell row.
    lis_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (i_value),
        .o_stat      (w_stat),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow)
    );

    // A result is shown in every drain cycle.
    assign o_valid = w_cmd.drain;

endmodule

`default_nettype wire

// ===== rtl/lis_checker.sv =====
// Port-level checks for the linear insertion sorter, bound to the top level.
// Depends on linear_insertion_sorter.
`default_nettype none

module lis_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_last,
    input wire logic o_valid,
    input wire logic o_last_res,
    input wire logic o_overflow
);

    // Results appear only while new transactions are held off.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while not busy");

    // The final result closes the run.
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_res) |=> !o_valid)
        else $error("strobe after final result");

    // A run continues until its final result.
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_res) |=> o_valid)
        else $error("run stopped before final result");

    // The overflow flag is the same on every result of one run.
    a_ovf_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_res) |=> $stable(o_overflow))
        else $error("overflow changed inside a run");

    // An element without the last flag starts no output.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> !o_valid)
        else $error("result after non-final element");

endmodule

bind linear_insertion_sorter lis_checker u_lis_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_last     (i_last),
    .o_valid    (o_valid),
    .o_last_res (o_last_res),
    .o_overflow (o_overflow)
);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for linear_insertion_sorter: sends sets of signed
// elements, predicts each sorted run and compares every strobed result.
// Depends on lis_pkg and the linear_insertion_sorter RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [lis_pkg::DATA_W-1:0] VAL_MIN =
        {1'b1, {(lis_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [lis_pkg::DATA_W-1:0] VAL_MAX =
        {1'b0, {(lis_pkg::DATA_W-1){1'b1}}};

    // One element of a sorted run as the block should strobe it.
    typedef struct packed {
        logic signed [lis_pkg::DATA_W-1:0] value;
        logic                              last;
        logic                              overflow;
    } t_sorted_elem;

    logic                              i_clk;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic signed [lis_pkg::DATA_W-1:0] i_value = '0;
    logic                              i_last = 1'b0;
    logic                              o_valid;
    logic signed [lis_pkg::DATA_W-1:0] o_value_res;
    logic                              o_last_res;
    logic                              o_overflow;

    // Predicted contents of the sorted store and the pending sorted output.
    logic signed [lis_pkg::DATA_W-1:0] held_elems[$];
    bit                                drop_seen;
    t_sorted_elem                      pending_sorted[$];

    int send_idle_pct;
    int mismatch_count;
    int elems_sent;
    int sets_sent;
    int results_checked;
    int dropped_runs;

    linear_insertion_sorter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stable insertion into the predicted store; a last element releases the run.
    task automatic predict_element(input logic signed [lis_pkg::DATA_W-1:0] v,
                                   input logic l);
        int pos;
        t_sorted_elem elem;
        if (held_elems.size() < lis_pkg::DEPTH) begin
            pos = held_elems.size();
            // Walk past strictly greater values only, so equal values keep order.
            while (pos > 0 && held_elems[pos-1] > v)
                pos--;
            held_elems.insert(pos, v);
        end else begin
            drop_seen = 1'b1;
        end
        if (l) begin
            for (int k = 0; k < held_elems.size(); k++) begin
                elem.value    = held_elems[k];
                elem.last     = (k == held_elems.size() - 1);
                elem.overflow = drop_seen;
                pending_sorted.push_back(elem);
            end
            if (drop_seen)
                dropped_runs++;
            sets_sent++;
            held_elems.delete();
            drop_seen = 1'b0;
        end
    endtask

    // Send one element: optional random gap, then hold start until busy is low.
    task automatic send_element(input logic signed [lis_pkg::DATA_W-1:0] v,
                                input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        i_last  <= l;
        do
            @(posedge i_clk);
        while (busy);
        elems_sent++;
        predict_element(v, l);
    endtask

    // Stop sending until every predicted result has been strobed.
    task automatic wait_sorted_drained();
        start <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Mix of full-range values, extremes and a narrow band that forces ties.
    function automatic logic signed [lis_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3, 4: return lis_pkg::DATA_W'(int'($urandom_range(16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++)
            send_element(pick_value(), k == n - 1);
    endtask

    // Extremes of the value range, zero and its neighbors in one set.
    task automatic test_extremes();
        send_element(VAL_MAX, 1'b0);
        send_element('0, 1'b0);
        send_element(VAL_MIN, 1'b0);
        send_element(-1, 1'b0);
        send_element(1, 1'b0);
        send_element(VAL_MAX, 1'b0);
        send_element(VAL_MIN, 1'b1);
    endtask

    // A set made of only its last element.
    task automatic test_single_element();
        send_element(VAL_MIN, 1'b1);
        send_element(VAL_MAX, 1'b1);
    endtask

    // Repeated values must come out grouped and in order.
    task automatic test_equal_values();
        send_element(5, 1'b0);
        send_element(5, 1'b0);
        send_element(-3, 1'b0);
        send_element(5, 1'b0);
        send_element(-3, 1'b1);
    endtask

    // Strictly descending input makes every insertion shift every held element.
    task automatic test_descending();
        for (int k = 0; k < 6; k++)
            send_element(lis_pkg::DATA_W'(100 - 37 * k), k == 5);
    endtask

    // Exactly DEPTH elements: the store fills without dropping anything.
    task automatic test_full_store();
        send_set(lis_pkg::DEPTH);
    endtask

    // More than DEPTH elements: the extra ones, the last among them, are dropped.
    task automatic test_overflow();
        send_set(lis_pkg::DEPTH + 3);
    endtask

    // Random sets, mostly short, some long, a few past the store size.
    task automatic test_random_sets(input int n_items);
        int sent;
        int r;
        int n;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 70)
                n = $urandom_range(8, 1);
            else if (r < 92)
                n = $urandom_range(lis_pkg::DEPTH, 9);
            else
                n = $urandom_range(lis_pkg::DEPTH + 6, lis_pkg::DEPTH + 1);
            send_set(n);
            sent += n;
        end
    endtask

    // Compare every strobed result with the oldest predicted one.
    t_sorted_elem exp_elem;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_sorted.size() == 0) begin
                $error("unexpected result transaction: value_res %0d", o_value_res);
                mismatch_count++;
            end else begin
                exp_elem = pending_sorted.pop_front();
                results_checked++;
                if (o_value_res !== exp_elem.value) begin
                    $error("value_res: expected %0d, got %0d", exp_elem.value, o_value_res);
                    mismatch_count++;
                end
                if (o_last_res !== exp_elem.last) begin
                    $error("last_res: expected %0b, got %0b", exp_elem.last, o_last_res);
                    mismatch_count++;
                end
                if (o_overflow !== exp_elem.overflow) begin
                    $error("overflow: expected %0b, got %0b", exp_elem.overflow, o_overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence: directed sets, then random sets under three idle patterns.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 6;
        test_extremes();
        test_single_element();
        test_equal_values();
        test_descending();
        test_full_store();
        test_overflow();
        test_random_sets(45);
        wait_sorted_drained();

        send_idle_pct = 86;
        test_random_sets(45);
        wait_sorted_drained();

        send_idle_pct = 0;
        test_random_sets(40);
        test_overflow();

        // Let the last run drain, then keep the clock running to catch a stray result.
        wait_sorted_drained();
        repeat (lis_pkg::DEPTH + 4) @(posedge i_clk);

        $display("Sent %0d elements in %0d sets (%0d with dropped elements).",
                 elems_sent, sets_sent, dropped_runs);
        $display("Checked %0d sorted results against the prediction.", results_checked);
        if (mismatch_count == 0 && pending_sorted.size() == 0) begin
            $display("linear_insertion_sorter: match");
        end else begin
            $display("linear_insertion_sorter: mismatch");
        end
        $finish;
    end

    // Safety net against a hung handshake.
    initial begin
        #400000;
        $display("linear_insertion_sorter: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/lis_pkg.sv
rtl/lis_ctrl.sv
rtl/lis_dp.sv
rtl/linear_insertion_sorter.sv
rtl/lis_checker.sv
sim/tb.sv
